// ===== rtl/rbs_pkg.sv =====
// Package for the ray/box slab test: widths, saturation limits, register map
// and the per-lane result struct. No dependencies.
package rbs_pkg;

    localparam int DW         = 32;
    localparam int NUMW       = 49;
    localparam int QW         = 32;
    localparam int DIV_STAGES = 32;
    localparam int PIPE       = DIV_STAGES + 1;
    localparam int TOLW       = 16;

    localparam logic signed [DW-1:0] Q_INF = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] Q_NEG = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_LOW_X  = 3'd0,
        REG_HIGH_X = 3'd1,
        REG_LOW_Y  = 3'd2,
        REG_HIGH_Y = 3'd3,
        REG_LOW_Z  = 3'd4,
        REG_HIGH_Z = 3'd5,
        REG_TOL    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic                 par;
        logic                 outside;
        logic signed [DW-1:0] k1;
        logic signed [DW-1:0] k2;
    } t_lane_res;

endpackage

// ===== rtl/rbs_ray_if.sv =====
// Ray channel: valid/ready handshake with origin and direction payload.
// Depends on nothing.
interface rbs_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

// ===== rtl/rbs_hit_if.sv =====
// Result channel: valid/ready handshake with a one-bit hit flag.
// Depends on nothing.
interface rbs_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

// ===== rtl/rbs_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// signed saturation of the result. Depends on rbs_pkg.
module rbs_div
    import rbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUMW-1:0]      i_num,
    input  logic [DW-1:0]        i_den,
    input  logic                 i_neg,
    output logic signed [DW-1:0] o_quot
);

    logic [NUMW-1:0] r_rem [0:DIV_STAGES];
    logic [QW-1:0]   r_q   [0:DIV_STAGES];
    logic [DW-1:0]   r_den [0:DIV_STAGES];
    logic            r_neg [0:DIV_STAGES];
    logic            r_ovf [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= {15'd0, i_num[NUMW-1:QW]} >= i_den;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        localparam int K = DIV_STAGES - 1 - j;
        logic [63:0] w_sh;
        logic [63:0] w_rem;
        logic        w_ge;
        assign w_sh  = {32'd0, r_den[j]} << K;
        assign w_rem = {15'd0, r_rem[j]};
        assign w_ge  = w_rem >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? r_rem[j] - w_sh[NUMW-1:0] : r_rem[j];
                r_q[j+1]   <= r_q[j] | (QW'(w_ge) << K);
                r_den[j+1] <= r_den[j];
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    logic [QW-1:0] w_q;
    assign w_q = r_q[DIV_STAGES];

    always_comb begin
        if (r_neg[DIV_STAGES]) begin
            if (r_ovf[DIV_STAGES] || (w_q[QW-1] && (w_q[QW-2:0] != '0)))
                o_quot = Q_NEG;
            else
                o_quot = DW'(-w_q);
        end else begin
            if (r_ovf[DIV_STAGES] || w_q[QW-1])
                o_quot = Q_INF;
            else
                o_quot = DW'(w_q);
        end
    end

endmodule

// ===== rtl/rbs_lane.sv =====
// One axis lane: orders the slab, flags parallel rays and runs the entry and
// exit divisions. Depends on rbs_pkg and rbs_div.
module rbs_lane
    import rbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_org,
    input  logic signed [DW-1:0] i_dir,
    input  logic signed [DW-1:0] i_low,
    input  logic signed [DW-1:0] i_high,
    input  logic [TOLW-1:0]      i_tol,
    output t_lane_res            o_res
);

    logic signed [DW-1:0] w_lo, w_hi;
    logic signed [DW:0]   w_dlo, w_dhi, w_tol, w_dir, w_d1, w_d2;
    logic [DW:0]          w_a1, w_a2, w_ad;
    logic                 w_par, w_out;
    logic                 r_par [0:PIPE-1];
    logic                 r_out [0:PIPE-1];

    assign w_lo  = (i_low > i_high) ? i_high : i_low;
    assign w_hi  = (i_low > i_high) ? i_low : i_high;
    assign w_dlo = (DW+1)'(w_lo) - (DW+1)'(i_org);
    assign w_dhi = (DW+1)'(w_hi) - (DW+1)'(i_org);
    assign w_tol = $signed({{(DW+1-TOLW){1'b0}}, i_tol});
    assign w_dir = (DW+1)'(i_dir);
    assign w_par = (w_dir <= w_tol) && (w_dir >= -w_tol);
    assign w_out = (i_org < w_lo) || (i_org > w_hi);
    assign w_d1  = i_dir[DW-1] ? w_dhi : w_dlo;
    assign w_d2  = i_dir[DW-1] ? w_dlo : w_dhi;
    assign w_a1  = w_d1[DW] ? $unsigned(-w_d1) : $unsigned(w_d1);
    assign w_a2  = w_d2[DW] ? $unsigned(-w_d2) : $unsigned(w_d2);
    assign w_ad  = i_dir[DW-1] ? $unsigned(-w_dir) : $unsigned(w_dir);

    rbs_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  ({w_a1, 16'd0}),
        .i_den  (w_ad[DW-1:0]),
        .i_neg  (w_d1[DW] ^ i_dir[DW-1]),
        .o_quot (o_res.k1)
    );

    rbs_div u_div2 (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  ({w_a2, 16'd0}),
        .i_den  (w_ad[DW-1:0]),
        .i_neg  (w_d2[DW] ^ i_dir[DW-1]),
        .o_quot (o_res.k2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_par[0] <= w_par;
            r_out[0] <= w_out;
            for (int s = 1; s < PIPE; s++) begin
                r_par[s] <= r_par[s-1];
                r_out[s] <= r_out[s-1];
            end
        end
    end

    assign o_res.par     = r_par[PIPE-1];
    assign o_res.outside = r_out[PIPE-1];

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Ray versus box slab test. Pipeline from input transfer to result valid: operand capture
// at the transfer, 32 divider stages, merge into the output register.
// Throughput: one ray per cycle unless o_hit stalls, set by the one-bit-per-stage dividers.
// Reset is synchronous, active low: clears valid bits, box bounds to 0 and
// tolerance to 1. Depends on rbs_pkg, rbs_ray_if, rbs_hit_if, rbs_lane.
module ray_box_slab_test
    import rbs_pkg::*;
#(
    parameter int AXES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbs_ray_if.sink     i_ray,
    rbs_hit_if.source   o_hit,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic signed [DW-1:0] r_low  [0:2];
    logic signed [DW-1:0] r_high [0:2];
    logic [TOLW-1:0]      r_tol;
    logic                 r_vld  [0:PIPE-1];
    logic                 r_ovld, r_hit;
    logic                 n_hit;
    logic                 w_en;
    t_reg_idx             w_idx;
    logic signed [DW-1:0] w_org [0:2];
    logic signed [DW-1:0] w_dir [0:2];
    t_lane_res            w_res [0:AXES-1];

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_low[a]  <= '0;
                r_high[a] <= '0;
            end
            r_tol <= TOLW'(1);
        end else if (i_psel && i_penable && i_pwrite) begin
            case (w_idx)
                REG_LOW_X:  r_low[0]  <= i_pwdata;
                REG_HIGH_X: r_high[0] <= i_pwdata;
                REG_LOW_Y:  r_low[1]  <= i_pwdata;
                REG_HIGH_Y: r_high[1] <= i_pwdata;
                REG_LOW_Z:  r_low[2]  <= i_pwdata;
                REG_HIGH_Z: r_high[2] <= i_pwdata;
                REG_TOL:    r_tol     <= i_pwdata[TOLW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LOW_X:  o_prdata = r_low[0];
            REG_HIGH_X: o_prdata = r_high[0];
            REG_LOW_Y:  o_prdata = r_low[1];
            REG_HIGH_Y: o_prdata = r_high[1];
            REG_LOW_Z:  o_prdata = r_low[2];
            REG_HIGH_Z: o_prdata = r_high[2];
            REG_TOL:    o_prdata = {16'd0, r_tol};
            default:    o_prdata = '0;
        endcase
    end

    assign w_org[0] = i_ray.origin_x;
    assign w_org[1] = i_ray.origin_y;
    assign w_org[2] = i_ray.origin_z;
    assign w_dir[0] = i_ray.dir_x;
    assign w_dir[1] = i_ray.dir_y;
    assign w_dir[2] = i_ray.dir_z;

    assign w_en        = !r_ovld || o_hit.ready;
    assign i_ray.ready = w_en;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        rbs_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_org  (w_org[a]),
            .i_dir  (w_dir[a]),
            .i_low  (r_low[a]),
            .i_high (r_high[a]),
            .i_tol  (r_tol),
            .o_res  (w_res[a])
        );
    end

    always_comb begin
        logic signed [DW:0] kmin, kmax, k1, k2;
        kmin  = -$signed({{(DW+1-TOLW){1'b0}}, r_tol});
        kmax  = (DW+1)'(Q_INF);
        n_hit = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            k1 = (DW+1)'(w_res[a].k1);
            k2 = (DW+1)'(w_res[a].k2);
            if (n_hit) begin
                if (w_res[a].par) begin
                    if (w_res[a].outside) n_hit = 1'b0;
                end else if (kmax <= k1 || k2 <= kmin) begin
                    n_hit = 1'b0;
                end else begin
                    if (k1 > kmin) kmin = k1;
                    if (k2 < kmax) kmax = k2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE; s++) r_vld[s] <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_ray.valid;
            for (int s = 1; s < PIPE; s++) r_vld[s] <= r_vld[s-1];
            r_ovld <= r_vld[PIPE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_hit <= n_hit;
    end

    assign o_hit.valid = r_ovld;
    assign o_hit.hit   = r_hit;

endmodule
